/* hw/rtl/wrapped_angle_slew_tracker_defines.svh */
// ----------------------------------------------------------------------------
// wrapped_angle_slew_tracker_defines
// assertion macros used by the checker file of the slew tracker
// ----------------------------------------------------------------------------
`ifndef WRAPPED_ANGLE_SLEW_TRACKER_DEFINES_SVH
`define WRAPPED_ANGLE_SLEW_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WAST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define WAST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/wast_pkg.sv */
// ----------------------------------------------------------------------------
// wast_pkg
// constants and command codes of the wrapped angle slew tracker
// ----------------------------------------------------------------------------
`default_nettype none

package wast_pkg;

	// field widths
	localparam int ANGLE_W = 16;
	localparam int TIME_W  = 16;
	localparam int SLEW_W  = 20;
	localparam int GAIN_W  = 16;
	localparam int CMD_W   = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	// angle units are 1/128 degree
	localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd46080;
	localparam logic [ANGLE_W-1:0] HALF_TURN = 16'd23040;
	localparam logic [ANGLE_W-1:0] MIN_STEP  = 16'd13;

	// register reset values
	localparam logic [SLEW_W-1:0] RESET_SLEW = 20'd89600;
	localparam logic [GAIN_W-1:0] RESET_GAIN = 16'd1920;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SLEW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 1'd1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_TARGET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET_CUR    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SNAP       = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/wrapped_angle_slew_tracker.sv */
// ----------------------------------------------------------------------------
// wrapped_angle_slew_tracker
// moves a current angle toward a target angle along the shorter way round
// ----------------------------------------------------------------------------
// A tick item goes through accept, three passes through the one shared 32x16
// multiplier (|diff|*gain, that product times elapsed time, and slew limit
// times elapsed time), then clamp and update, then write-out; set target, set
// current and snap go from accept straight to write-out. in_ready is high only
// while the sequencer idles; a finished result sits in the output register and
// does not hold off the next item, unless a second result is ready before the
// first is taken. Configuration writes are always accepted.
`default_nettype none

module wrapped_angle_slew_tracker
	import wast_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input item channel
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic [CMD_W-1:0]      cmd,
	input  wire logic [ANGLE_W-1:0]    angle_in,
	input  wire logic [TIME_W-1:0]     elapsed_time,
	// result item channel
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [ANGLE_W-1:0]    current_angle,
	output      logic [ANGLE_W-1:0]    target_angle
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_MUL3 = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_WR   = 3'd5;

	localparam int MUL_A_W = 32;
	localparam int PROD_W  = MUL_A_W + TIME_W;
	localparam int STEP_W  = 24;

	logic [2:0]         state_q;
	logic [SLEW_W-1:0]  slew_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [ANGLE_W-1:0] cur_q;
	logic [ANGLE_W-1:0] goal_q;
	logic [TIME_W-1:0]  dt_q;
	logic [ANGLE_W-1:0] dmag_q;
	logic               dneg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [STEP_W-1:0]  step_q;
	logic [SLEW_W-1:0]  lim_q;
	logic               out_valid_q;

	logic               in_fire;
	logic               out_free;
	logic [ANGLE_W-1:0] angle_wr;
	logic signed [17:0] diff_raw;
	logic signed [17:0] diff_w;
	logic [ANGLE_W-1:0] dmag;
	logic [MUL_A_W-1:0] mul_a;
	logic [TIME_W-1:0]  mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [STEP_W-1:0]  step_mag;
	logic               step_neg;
	logic [STEP_W-1:0]  lim_x;
	logic [STEP_W-1:0]  step_c;
	logic signed [17:0] cur_sum;
	logic signed [17:0] cur_wrap;
	logic [ANGLE_W-1:0] cur_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// out-of-range input angles lose one full turn
	assign angle_wr = (angle_in >= FULL_TURN) ? angle_in - FULL_TURN : angle_in;

	// shortest signed difference, wrapped across a half turn
	always_comb begin
		diff_raw = $signed({2'b00, goal_q}) - $signed({2'b00, cur_q});
		if (diff_raw > $signed({2'b00, HALF_TURN}))
			diff_w = diff_raw - $signed({2'b00, FULL_TURN});
		else if (diff_raw < -$signed({2'b00, HALF_TURN}))
			diff_w = diff_raw + $signed({2'b00, FULL_TURN});
		else
			diff_w = diff_raw;
		dmag = diff_w[17] ? ANGLE_W'(-diff_w) : diff_w[ANGLE_W-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = MUL_A_W'(dmag);
				mul_b = gain_q;
			end
			ST_MUL2: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = dt_q;
			end
			ST_MUL3: begin
				mul_a = MUL_A_W'(slew_q);
				mul_b = dt_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// floor of the signed product over 2^24, kept as sign and magnitude
	assign step_mag = prod_q[PROD_W-1:24] + STEP_W'(dneg_q && (prod_q[23:0] != '0));

	// clamp, lower bound first; a zero step counts as positive
	always_comb begin
		step_neg = dneg_q && (step_q != '0);
		lim_x    = STEP_W'(lim_q);
		if (step_neg) begin
			if (step_q > lim_x)
				step_c = lim_x;
			else if (step_q < STEP_W'(MIN_STEP))
				step_c = STEP_W'(MIN_STEP);
			else
				step_c = step_q;
		end else begin
			if (step_q < STEP_W'(MIN_STEP))
				step_c = STEP_W'(MIN_STEP);
			else if (step_q > lim_x)
				step_c = lim_x;
			else
				step_c = step_q;
		end
	end

	// apply step unless it overshoots, then wrap into one turn
	always_comb begin
		if (step_neg)
			cur_sum = $signed({2'b00, cur_q}) - $signed({2'b00, step_c[ANGLE_W-1:0]});
		else
			cur_sum = $signed({2'b00, cur_q}) + $signed({2'b00, step_c[ANGLE_W-1:0]});
		if (cur_sum >= $signed({2'b00, FULL_TURN}))
			cur_wrap = cur_sum - $signed({2'b00, FULL_TURN});
		else if (cur_sum < 18'sd0)
			cur_wrap = cur_sum + $signed({2'b00, FULL_TURN});
		else
			cur_wrap = cur_sum;
		if (step_c <= STEP_W'(dmag_q))
			cur_next = cur_wrap[ANGLE_W-1:0];
		else
			cur_next = goal_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_q <= RESET_SLEW;
			gain_q <= RESET_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_SLEW: slew_q <= cfg_data[SLEW_W-1:0];
				REG_GAIN:     gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and angle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			goal_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (cmd)
							CMD_TICK:       state_q <= ST_MUL1;
							CMD_SET_TARGET: begin
								goal_q  <= angle_wr;
								state_q <= ST_WR;
							end
							CMD_SET_CUR: begin
								cur_q   <= angle_wr;
								state_q <= ST_WR;
							end
							default: begin
								cur_q   <= goal_q;
								state_q <= ST_WR;
							end
						endcase
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_UPD;
				ST_UPD: begin
					cur_q   <= cur_next;
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// result valid: set on write-out, cleared once taken
			if (state_q == ST_WR && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire)
			dt_q <= elapsed_time;
		case (state_q)
			ST_MUL1: begin
				dmag_q <= dmag;
				dneg_q <= diff_w[17];
				prod_q <= mul_p;
			end
			ST_MUL2: prod_q <= mul_p;
			ST_MUL3: begin
				step_q <= step_mag;
				lim_q  <= mul_p[SLEW_W+15:16];
			end
			default: ;
		endcase
		if (state_q == ST_WR && out_free) begin
			current_angle <= cur_q;
			target_angle  <= goal_q;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/wast_checker.sv */
// ----------------------------------------------------------------------------
// wast_checker
// port-level checks of the slew tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "wrapped_angle_slew_tracker_defines.svh"

module wast_checker
	import wast_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [ANGLE_W-1:0]    current_angle,
	input wire logic [ANGLE_W-1:0]    target_angle
);

	// results always lie within one turn
	`WAST_ASSERT_SAME(a_out_range, out_valid, (current_angle < FULL_TURN) && (target_angle < FULL_TURN), "result angle out of range")

	// the sequencer is busy right after taking an item
	`WAST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accepting an item")

	// a new result only comes out of a busy sequencer
	`WAST_ASSERT_SAME(a_result_from_work, $rose(out_valid), !$past(in_ready), "result appeared without work")

	// a stalled result holds
	`WAST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(current_angle) && $stable(target_angle), "stalled result changed")

endmodule

bind wrapped_angle_slew_tracker wast_checker u_wast_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.current_angle (current_angle),
	.target_angle  (target_angle)
);

`default_nettype wire

/* tb/sv/wrapped_angle_slew_tracker_chk.sv */
// ----------------------------------------------------------------------------
// wrapped_angle_slew_tracker_chk
// tracks register writes and accepted items, predicts the current and target
// angle of each result, and compares them with what the block returns
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_angle_slew_tracker_chk
	import wast_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [CMD_W-1:0]      cmd,
	input  wire logic [ANGLE_W-1:0]    angle_in,
	input  wire logic [TIME_W-1:0]     elapsed_time,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [ANGLE_W-1:0]    current_angle,
	input  wire logic [ANGLE_W-1:0]    target_angle,
	output int                         fail_count,
	output int                         pending
);

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [ANGLE_W-1:0] cur;
		logic [ANGLE_W-1:0] tgt;
	} angle_pair_t;

	angle_pair_t        expected_angles[$];
	logic [ANGLE_W-1:0] cur_pos;
	logic [ANGLE_W-1:0] goal_pos;
	logic [SLEW_W-1:0]  slew_limit;
	logic [GAIN_W-1:0]  gain;

	// one line per mismatch, printing capped, counting not
	task automatic report_mismatch(string what, int got, int want);
		if (fail_count < PRINT_CAP)
			$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// reduce an angle input of one turn or more by one turn
	function automatic logic [ANGLE_W-1:0] fold_angle(logic [ANGLE_W-1:0] a);
		return (a >= FULL_TURN) ? a - FULL_TURN : a;
	endfunction

	// one tick of motion from the current angle toward the goal
	function automatic logic [ANGLE_W-1:0] slew_toward(
		input logic [ANGLE_W-1:0] from_pos,
		input logic [ANGLE_W-1:0] to_pos,
		input logic [SLEW_W-1:0]  slew_v,
		input logic [GAIN_W-1:0]  gain_v,
		input logic [TIME_W-1:0]  dt
	);
		longint full_turn, half_turn, min_step;
		longint diff, step, lim, adiff, astep, nxt;
		full_turn = longint'(FULL_TURN);
		half_turn = longint'(HALF_TURN);
		min_step  = longint'(MIN_STEP);

		// shortest signed difference
		diff = longint'(to_pos) - longint'(from_pos);
		if (diff > half_turn || diff < -half_turn)
			diff = (diff < 0) ? diff + full_turn : diff - full_turn;

		// proportional step with floor, and the rate limit
		step = (diff * longint'(gain_v) * longint'(dt)) >>> 24;
		lim  = (longint'(slew_v) * longint'(dt)) >>> 16;

		// clamp, lower bound tested first
		if (step < 0) begin
			if (step < -lim)
				step = -lim;
			else if (step > -min_step)
				step = -min_step;
		end else begin
			if (step < min_step)
				step = min_step;
			else if (step > lim)
				step = lim;
		end

		// snap on overshoot, then wrap into one turn
		adiff = (diff < 0) ? -diff : diff;
		astep = (step < 0) ? -step : step;
		nxt = (astep <= adiff) ? longint'(from_pos) + step : longint'(to_pos);
		if (nxt >= full_turn)
			nxt = nxt - full_turn;
		else if (nxt < 0)
			nxt = nxt + full_turn;
		return nxt[ANGLE_W-1:0];
	endfunction

	// watch the channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		angle_pair_t head;
		if (!arst_n) begin
			cur_pos    = '0;
			goal_pos   = '0;
			slew_limit = RESET_SLEW;
			gain       = RESET_GAIN;
			expected_angles.delete();
			pending = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_SLEW: slew_limit = cfg_data[SLEW_W-1:0];
					REG_GAIN:     gain       = cfg_data[GAIN_W-1:0];
					default:      ;
				endcase
			end

			// result items against the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_angles.size() == 0) begin
					report_mismatch("result with no item pending, current_angle",
						int'(current_angle), 0);
				end else begin
					head = expected_angles.pop_front();
					if (current_angle !== head.cur)
						report_mismatch("current_angle", int'(current_angle),
							int'(head.cur));
					if (target_angle !== head.tgt)
						report_mismatch("target_angle", int'(target_angle),
							int'(head.tgt));
				end
			end

			// input items update the predicted state
			if (in_valid && in_ready) begin
				case (cmd)
					CMD_TICK:
						cur_pos = slew_toward(cur_pos, goal_pos, slew_limit, gain,
							elapsed_time);
					CMD_SET_TARGET: goal_pos = fold_angle(angle_in);
					CMD_SET_CUR:    cur_pos  = fold_angle(angle_in);
					CMD_SNAP:       cur_pos  = goal_pos;
					default:        ;
				endcase
				expected_angles.push_back('{cur: cur_pos, tgt: goal_pos});
			end
			pending = expected_angles.size();
		end
	end

endmodule

`default_nettype wire

/* tb/sv/wrapped_angle_slew_tracker_tb.sv */
// ----------------------------------------------------------------------------
// wrapped_angle_slew_tracker_tb
// drives commands and register writes into the slew tracker under random
// idling on both sides, lets the checker compare every result, and reports
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_angle_slew_tracker_tb;
	import wast_pkg::*;

	localparam int STALL_LIMIT     = 3000;
	localparam int HOLD_CYCLES     = 300;
	localparam int ITEMS_PER_PHASE = 66;
	localparam int NUM_PHASES      = 9;
	localparam int TAIL_CYCLES     = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      cmd;
	logic [ANGLE_W-1:0]    angle_in;
	logic [TIME_W-1:0]     elapsed_time;
	logic                  out_valid;
	logic                  out_ready;
	logic [ANGLE_W-1:0]    current_angle;
	logic [ANGLE_W-1:0]    target_angle;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asks     = 0;
	int hold_taken    = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int target_hint   = 0;

	wrapped_angle_slew_tracker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.angle_in     (angle_in),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.current_angle(current_angle),
		.target_angle (target_angle)
	);

	wrapped_angle_slew_tracker_chk u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.angle_in     (angle_in),
		.elapsed_time (elapsed_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.current_angle(current_angle),
		.target_angle (target_angle),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_taken) begin
				hold_taken = hold_asks;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// offer one item, entered and left just after a falling edge
	task automatic send_item(logic [CMD_W-1:0] c, logic [ANGLE_W-1:0] a,
		logic [TIME_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		angle_in     <= a;
		elapsed_time <= t;
		if (c == CMD_SET_TARGET)
			target_hint = int'((a >= FULL_TURN) ? a - FULL_TURN : a);
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// drop the item valid and wait for every result to come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// write both registers, garbage in the unused data bits
	task automatic set_config(logic [SLEW_W-1:0] slew_v, logic [GAIN_W-1:0] gain_v);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MAX_SLEW;
		cfg_data  <= {(CFG_DATA_W - SLEW_W)'($urandom_range((1 << (CFG_DATA_W - SLEW_W)) - 1)),
			slew_v};
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_GAIN;
		cfg_data  <= {(CFG_DATA_W - GAIN_W)'($urandom_range((1 << (CFG_DATA_W - GAIN_W)) - 1)),
			gain_v};
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random item, mostly ticks toward a recent target
	task automatic send_random_item();
		logic [CMD_W-1:0]   c;
		logic [ANGLE_W-1:0] a;
		logic [TIME_W-1:0]  t;
		int                 sel;
		int                 near;
		sel = $urandom_range(99);
		if (sel < 55)
			c = CMD_TICK;
		else if (sel < 75)
			c = CMD_SET_TARGET;
		else if (sel < 90)
			c = CMD_SET_CUR;
		else
			c = CMD_SNAP;

		sel = $urandom_range(9);
		if (sel == 0) begin
			a = ANGLE_W'($urandom_range(65535, 46080));
		end else if (sel < 4) begin
			near = target_hint + int'($urandom_range(400)) - 200;
			if (near < 0)
				near = near + 46080;
			a = ANGLE_W'(near % 46080);
		end else begin
			a = ANGLE_W'($urandom_range(46079));
		end

		sel = $urandom_range(9);
		if (sel == 0)
			t = '0;
		else if (sel == 1)
			t = '1;
		else if (sel < 6)
			t = TIME_W'($urandom_range(2000));
		else
			t = TIME_W'($urandom_range(65535));
		send_item(c, a, t);
	endtask

	// stimulus
	initial begin
		logic [SLEW_W-1:0] slew_set[NUM_PHASES];
		logic [GAIN_W-1:0] gain_set[NUM_PHASES];
		slew_set = '{RESET_SLEW, 20'd0, 20'hFFFFF, 20'd5, 20'hFFFFF, 20'd0, 20'd89600,
			20'd3000, 20'd0};
		gain_set = '{RESET_GAIN, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd256,
			16'hFFFF, 16'd0};
		slew_set[5] = SLEW_W'($urandom_range(20'hFFFFF));
		gain_set[5] = GAIN_W'($urandom_range(16'hFFFF));
		slew_set[8] = SLEW_W'($urandom_range(20'hFFFFF));
		gain_set[8] = GAIN_W'($urandom_range(16'hFFFF));

		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		cmd          = CMD_TICK;
		angle_in     = '0;
		elapsed_time = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 28;
		recv_idle_pct = 76;

		// directed: reset registers, range edges and wrap cases
		send_item(CMD_TICK,       16'd0,     16'd1000);  // zero difference
		send_item(CMD_SET_TARGET, 16'd46079, 16'd0);
		send_item(CMD_TICK,       16'd0,     16'd0);     // zero elapsed time
		send_item(CMD_SET_CUR,    16'hFFFF,  16'hFFFF);  // out of range angle
		send_item(CMD_SET_TARGET, 16'd46080, 16'd0);     // exactly one turn
		send_item(CMD_TICK,       16'd0,     16'hFFFF);
		send_item(CMD_SET_CUR,    16'd23040, 16'd0);     // half turn apart
		send_item(CMD_TICK,       16'd0,     16'd100);
		send_item(CMD_SET_TARGET, 16'd23041, 16'd0);
		send_item(CMD_TICK,       16'hFFFF,  16'hFFFF);
		send_item(CMD_SNAP,       16'd0,     16'd0);
		send_item(CMD_SET_CUR,    16'd0,     16'd0);
		send_item(CMD_TICK,       16'd0,     16'd500);   // wraps the short way
		send_item(CMD_TICK,       16'd0,     16'd1);

		// directed: rate limit below the minimum step
		drain_results();
		set_config(20'd5, 16'hFFFF);
		send_item(CMD_SET_CUR,    16'd1000,  16'd0);
		send_item(CMD_SET_TARGET, 16'd40000, 16'd0);
		send_item(CMD_TICK,       16'd0,     16'hFFFF);
		send_item(CMD_TICK,       16'd0,     16'd3);
		send_item(CMD_SET_TARGET, 16'd2000,  16'd0);
		send_item(CMD_TICK,       16'd0,     16'd20000);
		send_item(CMD_TICK,       16'd0,     16'd0);
		send_item(CMD_SNAP,       16'd0,     16'd0);

		// random phases over several register settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			set_config(slew_set[p], gain_set[p]);
			if (p < 3) begin
				send_idle_pct = 28;
				recv_idle_pct = 76;
			end else if (p < 6) begin
				send_idle_pct = 76;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// back-pressure: hold results while items keep coming
			if (p == 6)
				hold_asks++;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_random_item();
		end

		// let everything drain, then give the verdict
		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
